/* rtl/zipcrypto_stream_decrypt_macros.svh */
// Assertion macros for the traditional zip stream decryptor.
`ifndef ZIPCRYPTO_STREAM_DECRYPT_MACROS_SVH
`define ZIPCRYPTO_STREAM_DECRYPT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ZCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ZCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ZCD_ASSERT_IMP(lbl, ante, cons, msg)
`define ZCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/zcd_pkg.sv */
// Shared types, constants and the CRC byte step of the zip stream decryptor.
`default_nettype none
package zcd_pkg;

  // Widths fixed by the item fields and the key state.
  localparam int unsigned KeyW  = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned HdrW  = 4;

  // Default number of header bytes swallowed after a restart.
  localparam int unsigned HeaderBytesDef = 12;

  // Cipher constants.
  localparam logic [KeyW-1:0] CrcPoly = 32'hEDB88320;
  localparam logic [KeyW-1:0] LcgMult = 32'd134775813;
  localparam logic [KeyW-1:0] InitK0  = 32'h12345678;
  localparam logic [KeyW-1:0] InitK1  = 32'h23456789;
  localparam logic [KeyW-1:0] InitK2  = 32'h34567890;

  // Command codes.
  localparam logic [CmdW-1:0] CmdRestart  = 2'd0;
  localparam logic [CmdW-1:0] CmdPassword = 2'd1;
  localparam logic [CmdW-1:0] CmdCipher   = 2'd2;

  // Request to the shared multiplier.
  typedef struct packed {
    logic            lcg;     // 1: LCG key step, 0: keystream square
    logic [15:0]     key_lo;  // low half of key two for the keystream
    logic [KeyW-1:0] acc;     // key one plus low byte of key zero
  } mul_req_t;

  // One reflected CRC-32 byte step without inversion.
  function automatic logic [KeyW-1:0] crc_step(input logic [KeyW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [KeyW-1:0] c;
    c = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return (crc >> 8) ^ c;
  endfunction

endpackage
`default_nettype wire

/* rtl/zipcrypto_stream_decrypt.sv */
// Top level of the traditional zip stream decryptor.
//
//  channel  direction  handshake               payload
//  input    in         in_valid_i / in_stall_o command_i, byte_value_i
//  output   out        out_valid_o/out_stall_i plain_byte_o
//
// Restart and unused commands end in the idle state; a password byte runs through
// K0, K1 and K2, a cipher byte through Ks, K0, K1 and K2: one shared multiplier
// serves the keystream square and the LCG step; CRC steps take separate states.
// After the header, a cipher byte's last key step waits while an earlier result
// is held at the output. Reset loads the initial keys and arms the header count.
`default_nettype none
`include "zipcrypto_stream_decrypt_macros.svh"
module zipcrypto_stream_decrypt #(
  parameter int unsigned HEADER_BYTES = zcd_pkg::HeaderBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [zcd_pkg::CmdW-1:0]      command_i,
  input  logic [zcd_pkg::ByteW-1:0]     byte_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [zcd_pkg::ByteW-1:0]     plain_byte_o
);

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StKs   = 3'd1;
  localparam logic [2:0] StK0   = 3'd2;
  localparam logic [2:0] StK1   = 3'd3;
  localparam logic [2:0] StK2   = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [zcd_pkg::KeyW-1:0]   key0_q, key0_d;
  logic [zcd_pkg::KeyW-1:0]   key1_q, key1_d;
  logic [zcd_pkg::KeyW-1:0]   key2_q, key2_d;
  logic [zcd_pkg::KeyW-1:0]   sum_q, sum_d;
  logic [zcd_pkg::HdrW-1:0]   hdr_q, hdr_d;
  logic [zcd_pkg::ByteW-1:0]  plain_q, plain_d;
  logic                       cipher_q, cipher_d;
  logic                       out_valid_q, out_valid_d;
  logic [zcd_pkg::ByteW-1:0]  out_byte_q, out_byte_d;

  logic                       in_beat;
  logic                       out_free;
  logic                       emit;
  logic [zcd_pkg::KeyW-1:0]   crc0;
  logic [zcd_pkg::KeyW-1:0]   prod;
  zcd_pkg::mul_req_t          mul_req;

  assign in_stall_o   = (state_q != StIdle);
  assign in_beat      = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign plain_byte_o = out_byte_q;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign emit         = cipher_q && (hdr_q == '0);
  assign crc0         = zcd_pkg::crc_step(key0_q, plain_q);

  // Shared multiplier: LCG step in K1, keystream square otherwise.
  always_comb begin
    mul_req.lcg    = (state_q == StK1);
    mul_req.key_lo = key2_q[15:0];
    mul_req.acc    = sum_q;
  end

  zcd_mul u_mul (
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Sequencer and key datapath.
  always_comb begin
    state_d     = state_q;
    key0_d      = key0_q;
    key1_d      = key1_q;
    key2_d      = key2_q;
    sum_d       = sum_q;
    hdr_d       = hdr_q;
    plain_d     = plain_q;
    cipher_d    = cipher_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          plain_d  = byte_value_i;
          cipher_d = (command_i == zcd_pkg::CmdCipher);
          unique case (command_i)
            zcd_pkg::CmdRestart: begin
              key0_d = zcd_pkg::InitK0;
              key1_d = zcd_pkg::InitK1;
              key2_d = zcd_pkg::InitK2;
              hdr_d  = zcd_pkg::HdrW'(HEADER_BYTES);
            end
            zcd_pkg::CmdPassword: begin
              state_d = StK0;
            end
            zcd_pkg::CmdCipher: begin
              state_d = StKs;
            end
            default: begin
              // The unused command leaves the keys and the header count unchanged.
              state_d = StIdle;
            end
          endcase
        end
      end
      StKs: begin
        // Recover the plain byte with the keystream byte.
        plain_d = plain_q ^ prod[15:8];
        state_d = StK0;
      end
      StK0: begin
        key0_d  = crc0;
        sum_d   = key1_q + {24'h0, crc0[7:0]};
        state_d = StK1;
      end
      StK1: begin
        key1_d  = prod + 32'd1;
        state_d = StK2;
      end
      StK2: begin
        // Last key step; a result waits for a free output register.
        if (!emit || out_free) begin
          key2_d  = zcd_pkg::crc_step(key2_q, key1_q[31:24]);
          state_d = StIdle;
          if (emit) begin
            out_valid_d = 1'b1;
            out_byte_d  = plain_q;
          end else if (cipher_q) begin
            hdr_d = hdr_q - 4'd1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control and key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      key0_q      <= zcd_pkg::InitK0;
      key1_q      <= zcd_pkg::InitK1;
      key2_q      <= zcd_pkg::InitK2;
      hdr_q       <= zcd_pkg::HdrW'(HEADER_BYTES);
      cipher_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key0_q      <= key0_d;
      key1_q      <= key1_d;
      key2_q      <= key2_d;
      hdr_q       <= hdr_d;
      cipher_q    <= cipher_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    plain_q    <= plain_d;
    out_byte_q <= out_byte_d;
  end

  // Assertions.
  `ZCD_ASSERT_NXT(a_cipher_to_ks, in_beat && (command_i == zcd_pkg::CmdCipher), state_q == StKs, "cipher beat did not start keystream step")
  `ZCD_ASSERT_IMP(a_out_from_k2, $rose(out_valid_q), $past(state_q) == StK2, "result appeared outside the final key step")
  `ZCD_ASSERT_NXT(a_pw_keeps_hdr, in_beat && (command_i == zcd_pkg::CmdPassword), $stable(hdr_q), "password beat changed header count")

endmodule
`default_nettype wire

/* rtl/zcd_mul.sv */
// Shared 32-bit multiplier for the keystream square and the LCG key step.
`default_nettype none
module zcd_mul (
  input  zcd_pkg::mul_req_t            req_i,
  output logic [zcd_pkg::KeyW-1:0]     prod_o
);

  logic [15:0]              ks_t;
  logic [zcd_pkg::KeyW-1:0] op_a;
  logic [zcd_pkg::KeyW-1:0] op_b;

  // Operand selection: keystream uses t and t^1, the LCG uses the fixed multiplier.
  always_comb begin
    ks_t = req_i.key_lo | 16'h0002;
    if (req_i.lcg) begin
      op_a = req_i.acc;
      op_b = zcd_pkg::LcgMult;
    end else begin
      op_a = {16'h0, ks_t};
      op_b = {16'h0, ks_t ^ 16'h0001};
    end
  end

  // Low 32 bits of the product.
  assign prod_o = op_a * op_b;

endmodule
`default_nettype wire

/* tb/sv/tb_zipcrypto_stream_decrypt.sv */
// Self-checking testbench for the traditional zip stream decryptor.
`timescale 1ns / 1ps
module tb_zipcrypto_stream_decrypt;

  localparam int unsigned HdrBytes = zcd_pkg::HeaderBytesDef;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold = 300;
  // The fourth command code has no function and must leave the keys alone.
  localparam logic [zcd_pkg::CmdW-1:0] CmdUnused = 2'd3;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [zcd_pkg::CmdW-1:0]  command_i;
  logic [zcd_pkg::ByteW-1:0] byte_value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [zcd_pkg::ByteW-1:0] plain_byte_o;

  zipcrypto_stream_decrypt #(
    .HEADER_BYTES(HdrBytes)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .byte_value_i(byte_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .plain_byte_o(plain_byte_o)
  );

  // Predicted cipher state, kept in step with accepted input beats.
  logic [zcd_pkg::KeyW-1:0]  key0, key1, key2;
  logic [zcd_pkg::HdrW-1:0]  hdr_left;
  logic [zcd_pkg::ByteW-1:0] expected_plain[$];

  // Idling controls shared with the sender and the receiver.
  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned hold_cycles;
  bit          beat_taken;

  int unsigned errors;
  int unsigned cycle_cnt;
  int unsigned beats_sent;
  int unsigned plain_checked;
  int unsigned n_restart, n_password, n_cipher, n_unused;
  logic [zcd_pkg::ByteW-1:0] want_byte;

  // Bitwise reflected CRC-32 over one byte, no inversion.
  function automatic logic [zcd_pkg::KeyW-1:0] crc_advance(
      input logic [zcd_pkg::KeyW-1:0] crc,
      input logic [zcd_pkg::ByteW-1:0] data);
    logic [zcd_pkg::KeyW-1:0] r;
    r = crc ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? zcd_pkg::CrcPoly : '0);
    end
    return r;
  endfunction

  // Keystream byte from the low half of key two.
  function automatic logic [zcd_pkg::ByteW-1:0] keystream_of(
      input logic [zcd_pkg::KeyW-1:0] k2);
    logic [15:0] t;
    logic [31:0] prod;
    t = k2[15:0] | 16'h0002;
    prod = {16'h0, t} * {16'h0, t ^ 16'h0001};
    return prod[15:8];
  endfunction

  // Fold one byte into the three keys.
  function automatic void keys_mix(input logic [zcd_pkg::ByteW-1:0] p);
    key0 = crc_advance(key0, p);
    key1 = (key1 + {24'h0, key0[7:0]}) * zcd_pkg::LcgMult + 32'd1;
    key2 = crc_advance(key2, key1[31:24]);
  endfunction

  function automatic void keys_load();
    key0 = zcd_pkg::InitK0;
    key1 = zcd_pkg::InitK1;
    key2 = zcd_pkg::InitK2;
    hdr_left = zcd_pkg::HdrW'(HdrBytes);
  endfunction

  // Advance the predicted state by one accepted beat and queue any plain byte.
  function automatic void decrypt_predict(input logic [zcd_pkg::CmdW-1:0] cmd,
                                          input logic [zcd_pkg::ByteW-1:0] val);
    logic [zcd_pkg::ByteW-1:0] plain;
    case (cmd)
      zcd_pkg::CmdRestart: begin
        keys_load();
        n_restart++;
      end
      zcd_pkg::CmdPassword: begin
        keys_mix(val);
        n_password++;
      end
      zcd_pkg::CmdCipher: begin
        plain = val ^ keystream_of(key2);
        keys_mix(plain);
        if (hdr_left != 0) begin
          hdr_left = hdr_left - 1'b1;
        end else begin
          expected_plain.push_back(plain);
        end
        n_cipher++;
      end
      default: begin
        n_unused++;
      end
    endcase
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d plain bytes outstanding", $time, expected_plain.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every output beat against the oldest predicted plain byte.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beat_taken = 1'b1;
      if (expected_plain.size() == 0) begin
        errors++;
        $display("%0t: unexpected plain byte, expected none, actual %02h",
                 $time, plain_byte_o);
      end else begin
        want_byte = expected_plain.pop_front();
        plain_checked++;
        if (plain_byte_o !== want_byte) begin
          errors++;
          $display("%0t: plain_byte mismatch, expected %02h, actual %02h",
                   $time, want_byte, plain_byte_o);
        end
      end
    end
  end

  // Output side: random pause after each beat when idling is enabled, plus a long hold on request.
  initial begin : result_sink
    int unsigned pause;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i = 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        out_stall_i = 1'b0;
      end else if (beat_taken) begin
        beat_taken = 1'b0;
        pause = sink_idle_en ? $urandom_range(0, 3) : 0;
        if (pause != 0) begin
          out_stall_i = 1'b1;
          repeat (pause) @(negedge clk_i);
        end
        out_stall_i = 1'b0;
      end
    end
  end

  // Offer one beat after a random gap when idling is enabled and return once it is accepted.
  task automatic push_beat(input logic [zcd_pkg::CmdW-1:0] cmd,
                           input logic [zcd_pkg::ByteW-1:0] val);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      command_i = zcd_pkg::CmdW'($urandom_range(0, 3));
      byte_value_i = zcd_pkg::ByteW'($urandom_range(0, 255));
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i = cmd;
    byte_value_i = val;
    do @(posedge clk_i); while (in_stall_o);
    decrypt_predict(cmd, val);
    beats_sent++;
  endtask

  // Stop offering and wait until every predicted plain byte has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_plain.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, every command and each corner of the header logic.
  task automatic test_directed();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    // Cipher and unused beats straight out of reset use the reset keys.
    push_beat(zcd_pkg::CmdCipher, 8'h00);
    push_beat(CmdUnused, 8'hFF);
    push_beat(zcd_pkg::CmdRestart, 8'h00);
    push_beat(zcd_pkg::CmdRestart, 8'hFF);
    push_beat(zcd_pkg::CmdPassword, 8'h00);
    push_beat(zcd_pkg::CmdPassword, 8'hFF);
    push_beat(zcd_pkg::CmdPassword, 8'hA5);
    // A full header with extreme and alternating bytes.
    for (int i = 0; i < 12; i++) begin
      push_beat(zcd_pkg::CmdCipher,
                (i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'h5A));
    end
    push_beat(zcd_pkg::CmdCipher, 8'hFF);
    push_beat(zcd_pkg::CmdCipher, 8'h00);
    // A password beat after cipher beats keeps the header count as it is.
    push_beat(zcd_pkg::CmdPassword, 8'h5A);
    push_beat(zcd_pkg::CmdCipher, 8'h7E);
    push_beat(CmdUnused, 8'h00);
    push_beat(zcd_pkg::CmdCipher, 8'h81);
    wait_drained();
  endtask

  // Mostly well-formed sessions with random content, some noise and breaks.
  task automatic test_random_sessions(input int unsigned n_beats);
    int unsigned start_cnt;
    int unsigned pw_len;
    int unsigned body_len;
    start_cnt = beats_sent;
    while (beats_sent - start_cnt < n_beats) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          push_beat(zcd_pkg::CmdW'($urandom_range(0, 3)),
                    zcd_pkg::ByteW'($urandom_range(0, 255)));
        end
      end else begin
        push_beat(zcd_pkg::CmdRestart, zcd_pkg::ByteW'($urandom_range(0, 255)));
        pw_len = $urandom_range(0, 12);
        repeat (pw_len) begin
          push_beat(zcd_pkg::CmdPassword, zcd_pkg::ByteW'($urandom_range(0, 255)));
        end
        // Some sessions break off inside the header.
        body_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, HdrBytes - 1)
                                               : HdrBytes + $urandom_range(1, 40);
        repeat (body_len) begin
          if ($urandom_range(0, 19) == 0) begin
            push_beat($urandom_range(0, 1) ? zcd_pkg::CmdPassword : CmdUnused,
                      zcd_pkg::ByteW'($urandom_range(0, 255)));
          end
          push_beat(zcd_pkg::CmdCipher, zcd_pkg::ByteW'($urandom_range(0, 255)));
        end
      end
    end
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps going.
  task automatic test_output_backpressure();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    hold_cycles = LongHold;
    push_beat(zcd_pkg::CmdRestart, 8'h00);
    repeat (HdrBytes + 60) begin
      push_beat(zcd_pkg::CmdCipher, zcd_pkg::ByteW'($urandom_range(0, 255)));
    end
    wait_drained();
  endtask

  // Sender pauses mid-session until every result is out, then resumes.
  task automatic test_drain_pause();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    push_beat(zcd_pkg::CmdRestart, 8'h00);
    repeat (4) begin
      push_beat(zcd_pkg::CmdPassword, zcd_pkg::ByteW'($urandom_range(0, 255)));
    end
    repeat (HdrBytes + 8) begin
      push_beat(zcd_pkg::CmdCipher, zcd_pkg::ByteW'($urandom_range(0, 255)));
    end
    wait_drained();
    repeat (10) begin
      push_beat(zcd_pkg::CmdCipher, zcd_pkg::ByteW'($urandom_range(0, 255)));
    end
    wait_drained();
  endtask

  // Test sequence.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = zcd_pkg::CmdRestart;
    byte_value_i = 8'h00;
    hold_cycles = 0;
    beat_taken = 1'b0;
    keys_load();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_sessions(600);
    test_output_backpressure();
    test_drain_pause();
    test_random_sessions(600);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d beats: %0d restart, %0d password, %0d cipher, %0d unused.",
             beats_sent, n_restart, n_password, n_cipher, n_unused);
    $display("Checked %0d plain bytes, %0d mismatches, in %0d cycles.",
             plain_checked, errors, cycle_cnt);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* zipcrypto_stream_decrypt.f */
+incdir+rtl
rtl/zcd_pkg.sv
rtl/zcd_mul.sv
rtl/zipcrypto_stream_decrypt.sv
tb/sv/tb_zipcrypto_stream_decrypt.sv
